// ----- rtl/core/amo_pkg.sv -----
// Shared types and constants for the 64-bit atomic memory operation unit.
// Holds the operation codes, the state machine type and the ALU result struct.
// No dependencies.
package amo_pkg;

   localparam int DATA_W        = 64;
   localparam int FUNC_W        = 4;
   localparam int ADDR_IN_W     = 8;
   localparam int BIT_W         = 6;
   localparam int WORDS_DEFAULT = 256;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ = 4'd0,
      FUNC_XCHG = 4'd1,
      FUNC_CAS  = 4'd2,
      FUNC_ADD  = 4'd3,
      FUNC_AND  = 4'd4,
      FUNC_OR   = 4'd5,
      FUNC_XOR  = 4'd6,
      FUNC_TCLR = 4'd7,
      FUNC_TSET = 4'd8
   } func_type;

   typedef enum logic {
      ST_CLEAR = 1'b0,
      ST_RUN   = 1'b1
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] new_word;
      logic [DATA_W-1:0] data;
      logic              flag;
   } alu_out_type;

endpackage

// ----- rtl/core/amo_req_if.sv -----
// Request channel of the atomic memory operation unit: valid/ready plus payload.
// Depends on amo_pkg for field widths.
interface amo_req_if;
   logic                           valid;
   logic                           ready;
   logic [amo_pkg::FUNC_W-1:0]     func;
   logic [amo_pkg::ADDR_IN_W-1:0]  word_addr;
   logic [amo_pkg::DATA_W-1:0]     operand;
   logic [amo_pkg::DATA_W-1:0]     compare_value;
   logic [amo_pkg::BIT_W-1:0]      bit_index;

   modport source (output valid, func, word_addr, operand, compare_value, bit_index,
                   input ready);
   modport sink   (input valid, func, word_addr, operand, compare_value, bit_index,
                   output ready);
endinterface

// ----- rtl/core/amo_rsp_if.sv -----
// Response channel of the atomic memory operation unit: valid/ready plus payload.
// Depends on amo_pkg for field widths.
interface amo_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [amo_pkg::DATA_W-1:0]  data;
   logic                        flag;

   modport source (output valid, data, flag, input ready);
   modport sink   (input valid, data, flag, output ready);
endinterface

// ----- rtl/core/atomic_memory_op_unit_64.sv -----
// Atomic memory operation unit: WORDS 64-bit words in one synchronous RAM, one
// read-modify-write per request. A request is accepted into a read stage that
// addresses the RAM; from that stage the read word (or the word written by the
// previous request, forwarded from a bypass register) goes through the ALU, is
// written back and lands in the response register. Throughput is one request
// per cycle while the response is not stalled; the registered read of the single
// RAM read port is why the read stage sits before the ALU. After reset the unit
// runs a clearing pass, writing zero to one word per cycle, with req_bus.ready
// low throughout. Addresses at or beyond WORDS wrap modulo WORDS.
// Depends on amo_pkg, amo_req_if, amo_rsp_if, amo_ram and amo_alu.
module atomic_memory_op_unit_64 #(
   parameter int WORDS = amo_pkg::WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   amo_req_if.sink     req_bus,
   amo_rsp_if.source   rsp_bus
);

   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW = $clog2(WORDS + 1);

   amo_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic               clearing;

   logic                              s1_valid_ff, s1_valid_in;
   logic [amo_pkg::FUNC_W-1:0]        s1_func_ff;
   logic [AW-1:0]                     s1_addr_ff;
   logic [amo_pkg::DATA_W-1:0]        s1_operand_ff;
   logic [amo_pkg::DATA_W-1:0]        s1_compare_ff;
   logic [amo_pkg::BIT_W-1:0]         s1_bit_ff;

   logic                              fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]                     fwd_addr_ff;
   logic [amo_pkg::DATA_W-1:0]        fwd_data_ff;

   logic                              out_valid_ff, out_valid_in;
   logic [amo_pkg::DATA_W-1:0]        out_data_ff;
   logic                              out_flag_ff;

   logic                              req_ready;
   logic                              accept;
   logic                              advance;
   logic [amo_pkg::ADDR_IN_W-1:0]     addr_red;
   logic [AW-1:0]                     req_addr;
   logic [amo_pkg::DATA_W-1:0]        rdata;
   logic [amo_pkg::DATA_W-1:0]        old_word;
   amo_pkg::alu_out_type              alu_out;

   logic                              mem_we;
   logic [AW-1:0]                     mem_waddr;
   logic [amo_pkg::DATA_W-1:0]        mem_wdata;
   logic [AW-1:0]                     mem_raddr;

   // state machine: clearing pass, then normal operation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= amo_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      clearing   = 1'b0;
      unique case (state_ff)
         amo_pkg::ST_CLEAR: begin
            clearing   = 1'b1;
            clr_cnt_in = clr_cnt_ff + CW'(1);
            if (clr_cnt_ff == CW'(WORDS - 1)) begin
               state_in = amo_pkg::ST_RUN;
            end
         end
         amo_pkg::ST_RUN: begin
         end
         default: begin
            state_in = amo_pkg::ST_CLEAR;
         end
      endcase
   end

   // handshake
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_ready = (state_ff == amo_pkg::ST_RUN) && (!s1_valid_ff || advance);
   assign accept    = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   // wrap the address modulo WORDS by restoring subtraction of shifted WORDS
   always_comb begin
      addr_red = req_bus.word_addr;
      for (int k = 7; k >= 0; k--) begin
         if (int'(addr_red) >= (WORDS << k)) begin
            addr_red = addr_red - amo_pkg::ADDR_IN_W'(WORDS << k);
         end
      end
      req_addr = AW'(addr_red);
   end

   // re-read the held address while stalled so the read data stays current
   assign mem_raddr = accept ? req_addr : s1_addr_ff;
   assign mem_we    = clearing || advance;
   assign mem_waddr = clearing ? clr_cnt_ff[AW-1:0] : s1_addr_ff;
   assign mem_wdata = clearing ? '0 : alu_out.new_word;

   amo_ram #(
      .WIDTH (amo_pkg::DATA_W),
      .DEPTH (WORDS)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (rdata)
   );

   // bypass the write of the previous cycle, which the RAM read missed
   assign old_word = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rdata;

   amo_alu u_alu (
      .func          (s1_func_ff),
      .old_word      (old_word),
      .operand       (s1_operand_ff),
      .compare_value (s1_compare_ff),
      .bit_index     (s1_bit_ff),
      .result        (alu_out)
   );

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      fwd_valid_in = advance;
      out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff    <= req_bus.func;
         s1_addr_ff    <= req_addr;
         s1_operand_ff <= req_bus.operand;
         s1_compare_ff <= req_bus.compare_value;
         s1_bit_ff     <= req_bus.bit_index;
      end
      if (advance) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= alu_out.new_word;
         out_data_ff <= alu_out.data;
         out_flag_ff <= alu_out.flag;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_data_ff;
   assign rsp_bus.flag  = out_flag_ff;

`ifndef SYNTH
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == amo_pkg::ST_CLEAR) |-> !req_ready)
      else $error("request accepted during clearing pass");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == amo_pkg::ST_CLEAR) |-> (!s1_valid_ff && !out_valid_ff))
      else $error("pipeline busy during clearing pass");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("response appeared without a stage advance");

   a_fwd_hit_new: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) |-> $past(accept))
      else $error("bypass hit on a request that was not just accepted");
`endif

endmodule

// ----- rtl/core/amo_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module amo_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/amo_alu.sv -----
// Combinational modify step: new word, returned data and flag for one request.
// Depends on amo_pkg for operation codes and the result struct.
module amo_alu (
   input  logic [amo_pkg::FUNC_W-1:0]  func,
   input  logic [amo_pkg::DATA_W-1:0]  old_word,
   input  logic [amo_pkg::DATA_W-1:0]  operand,
   input  logic [amo_pkg::DATA_W-1:0]  compare_value,
   input  logic [amo_pkg::BIT_W-1:0]   bit_index,
   output amo_pkg::alu_out_type        result
);

   logic [amo_pkg::DATA_W-1:0] mask;
   logic                       bit_old;

   always_comb begin
      mask    = amo_pkg::DATA_W'(1) << bit_index;
      bit_old = |(old_word & mask);

      // unchanged word, zero data and flag unless the operation says otherwise
      result.new_word = old_word;
      result.data     = '0;
      result.flag     = 1'b0;

      unique case (amo_pkg::func_type'(func))
         amo_pkg::FUNC_READ: begin
            result.data = old_word;
         end
         amo_pkg::FUNC_XCHG: begin
            result.new_word = operand;
            result.data     = old_word;
         end
         amo_pkg::FUNC_CAS: begin
            if (old_word == compare_value) begin
               result.new_word = operand;
               result.flag     = 1'b1;
            end
         end
         amo_pkg::FUNC_ADD: begin
            result.new_word = old_word + operand;
            result.data     = old_word + operand;
         end
         amo_pkg::FUNC_AND: begin
            result.new_word = old_word & operand;
            result.data     = old_word & operand;
         end
         amo_pkg::FUNC_OR: begin
            result.new_word = old_word | operand;
            result.data     = old_word | operand;
         end
         amo_pkg::FUNC_XOR: begin
            result.new_word = old_word ^ operand;
            result.data     = old_word ^ operand;
         end
         amo_pkg::FUNC_TCLR: begin
            result.new_word = old_word & ~mask;
            result.flag     = bit_old;
         end
         amo_pkg::FUNC_TSET: begin
            result.new_word = old_word | mask;
            result.flag     = bit_old;
         end
         default: begin
         end
      endcase
   end

endmodule
